// ----- hdl/ramt_pkg.sv -----
// Shared types and constants for the range-add / range-max tree unit.
package ramt_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int VALUE_BITS_DEF = 32;
  localparam int POS_W          = 11;
  localparam int DATA_W         = 32;

  localparam logic FN_ADD = 1'b0;
  localparam logic FN_MAX = 1'b1;

  localparam logic ST_DONE = 1'b0;
  localparam logic ST_BAD  = 1'b1;

  typedef struct packed {
    logic                     func;
    logic [POS_W-1:0]         left_index;
    logic [POS_W-1:0]         right_index;
    logic signed [DATA_W-1:0] delta;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_max;
    logic                     status;
  } resp_t;

endpackage

// ----- hdl/range_add_range_max_tree_unit.sv -----
// Lazy segment tree: range add and range maximum over a node memory, walked by a sequencer.
// An item walks the tree depth-first from the root. A node the range covers is read and
//   updated in place (add) or folded into the running maximum (max); a node it splits has any
//   nonzero pending add pushed to both children, is descended through and returned to, and for
//   an add gets its maximum refreshed from the children's maxima read back. The node memory has
//   one read and one write port. One item is in the unit at a time; a bad range (left index zero,
//   left above right, or right above the size) skips the walk and goes straight to the result.
// Reset (synchronous, rst high) and every size write run a clearing pass over all 4*CAPACITY
//   nodes of the node memory, during which no item is taken.
module range_add_range_max_tree_unit #(
  parameter int CAPACITY   = ramt_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ramt_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ramt_pkg::req_t             in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ramt_pkg::resp_t            out_item,
  input  logic                       cfg_we,
  input  logic [ramt_pkg::POS_W-1:0] cfg_wdata
);
  import ramt_pkg::*;

  localparam int VB    = VALUE_BITS;
  localparam int NODES = 4 * CAPACITY;
  localparam int AW    = $clog2(NODES);
  localparam int CP_W  = $clog2(CAPACITY + 1);
  localparam int PW    = (CP_W > POS_W) ? CP_W : POS_W;
  localparam int SD    = $clog2(CAPACITY) + 1;   // deepest chain of split nodes
  localparam int SPW   = $clog2(SD + 1);
  localparam int IW    = $clog2(SD);

  typedef struct packed {
    logic [VB-1:0] mx;
    logic [VB-1:0] pd;
  } node_t;

  // One frame per split node on the current path.
  typedef struct packed {
    logic [AW-1:0] p;
    logic [PW-1:0] lo;
    logic [PW-1:0] hi;
    logic          right;   // right child under way (left child done or skipped)
  } frame_t;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CLEAR = 11'b00000000010,
    S_VISIT = 11'b00000000100,
    S_VDATA = 11'b00000001000,
    S_PUSHL = 11'b00000010000,
    S_PUSHR = 11'b00000100000,
    S_DESC  = 11'b00001000000,
    S_RET   = 11'b00010000000,
    S_FIXL  = 11'b00100000000,
    S_FIXR  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t         state;
  logic [PW-1:0]  size;
  logic [AW-1:0]  clr_addr;

  // Item registers.
  logic           op;
  logic           bad;
  logic [PW-1:0]  ql;
  logic [PW-1:0]  qr;
  logic [VB-1:0]  dlt;

  // Walk registers.
  logic [AW-1:0]  cur_p;
  logic [PW-1:0]  cur_lo;
  logic [PW-1:0]  cur_hi;
  logic [VB-1:0]  carry;
  logic [VB-1:0]  tmp;
  logic [VB-1:0]  acc;
  logic           have;
  logic [SPW-1:0] sp;
  frame_t         stack [SD];

  // Node memory: one write port, one registered read port.
  node_t          mem [NODES];
  node_t          rdata;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  node_t          wr_data;
  logic [AW-1:0]  rd_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // Derived values.
  logic [PW:0]     cur_sum;
  logic [PW-1:0]   cur_mid;
  logic [AW-1:0]   cur_lc;
  logic [AW-1:0]   cur_rc;
  logic [SPW-1:0]  sp_m1;
  frame_t          top;
  logic [PW:0]     top_sum;
  logic [PW-1:0]   top_mid;
  logic [AW-1:0]   top_lc;
  logic            covered;
  logic [PW-1:0]   in_ql;
  logic [PW-1:0]   in_qr;
  logic [PW-1:0]   cfg_v;
  logic [63:0]     d_ext;
  logic [63:0]     acc_ext;
  logic [VB-1:0]   fix_max;
  logic [VB-1:0]   acc_max;

  assign cur_sum = {1'b0, cur_lo} + {1'b0, cur_hi};
  assign cur_mid = cur_sum[PW:1];
  assign cur_lc  = {cur_p[AW-2:0], 1'b0};
  assign cur_rc  = {cur_p[AW-2:0], 1'b1};
  assign sp_m1   = sp - SPW'(1);
  assign top     = stack[sp_m1[IW-1:0]];
  assign top_sum = {1'b0, top.lo} + {1'b0, top.hi};
  assign top_mid = top_sum[PW:1];
  assign top_lc  = {top.p[AW-2:0], 1'b0};
  assign covered = (ql <= cur_lo) && (cur_hi <= qr);
  assign in_ql   = PW'(in_item.left_index);
  assign in_qr   = PW'(in_item.right_index);
  assign d_ext   = 64'(signed'(in_item.delta));
  assign acc_ext = 64'(signed'(acc));
  assign fix_max = ($signed(tmp) >= $signed(rdata.mx)) ? tmp : rdata.mx;
  assign acc_max = (have && ($signed(acc) >= $signed(rdata.mx))) ? acc : rdata.mx;

  always_comb begin
    cfg_v = PW'(cfg_wdata);
    if (cfg_v == '0) begin
      cfg_v = PW'(1);
    end else if (cfg_v > PW'(CAPACITY)) begin
      cfg_v = PW'(CAPACITY);
    end
  end

  assign in_ready = (state == S_IDLE);

  // Memory port control.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_p;
    wr_data = '0;
    rd_addr = cur_p;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      S_VDATA: begin
        rd_addr = cur_lc;
        if (covered) begin
          wr_en = (op == FN_ADD);
          wr_data.mx = rdata.mx + dlt;
          wr_data.pd = rdata.pd + dlt;
        end else if (rdata.pd != '0) begin
          wr_en      = 1'b1;
          wr_data.mx = rdata.mx;
        end
      end
      S_PUSHL: begin
        wr_en      = 1'b1;
        wr_addr    = cur_lc;
        wr_data.mx = rdata.mx + carry;
        wr_data.pd = rdata.pd + carry;
        rd_addr    = cur_rc;
      end
      S_PUSHR: begin
        wr_en      = 1'b1;
        wr_addr    = cur_rc;
        wr_data.mx = rdata.mx + carry;
        wr_data.pd = rdata.pd + carry;
      end
      S_RET: begin
        rd_addr = top_lc;
      end
      S_FIXL: begin
        rd_addr = cur_rc;
      end
      S_FIXR: begin
        wr_en      = 1'b1;
        wr_data.mx = fix_max;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      size      <= PW'(CAPACITY);
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once taken, unless the finished walk refills the slot now.
      if (out_valid && out_ready && (cfg_we || (state != S_DONE))) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        size     <= cfg_v;
        clr_addr <= '0;
        state    <= S_CLEAR;
      end else begin
        case (state)
          S_IDLE: begin
            if (in_valid) begin
              op     <= in_item.func;
              ql     <= in_ql;
              qr     <= in_qr;
              dlt    <= d_ext[VB-1:0];
              bad    <= (in_ql == '0) || (in_ql > in_qr) || (in_qr > size);
              cur_p  <= AW'(1);
              cur_lo <= PW'(1);
              cur_hi <= size;
              acc    <= '0;
              have   <= 1'b0;
              sp     <= '0;
              if ((in_ql == '0) || (in_ql > in_qr) || (in_qr > size)) begin
                state <= S_DONE;
              end else begin
                state <= S_VISIT;
              end
            end
          end
          S_CLEAR: begin
            clr_addr <= clr_addr + AW'(1);
            if (clr_addr == AW'(NODES - 1)) begin
              state <= S_IDLE;
            end
          end
          S_VISIT: begin
            state <= S_VDATA;
          end
          S_VDATA: begin
            carry <= rdata.pd;
            if (covered) begin
              if (op == FN_MAX) begin
                acc  <= acc_max;
                have <= 1'b1;
              end
              state <= S_RET;
            end else if (rdata.pd != '0) begin
              state <= S_PUSHL;
            end else begin
              state <= S_DESC;
            end
          end
          S_PUSHL: begin
            state <= S_PUSHR;
          end
          S_PUSHR: begin
            state <= S_DESC;
          end
          S_DESC: begin
            // Save this node and descend into the first child that meets the range.
            stack[sp[IW-1:0]].p  <= cur_p;
            stack[sp[IW-1:0]].lo <= cur_lo;
            stack[sp[IW-1:0]].hi <= cur_hi;
            sp <= sp + SPW'(1);
            if (ql <= cur_mid) begin
              stack[sp[IW-1:0]].right <= 1'b0;
              cur_p  <= cur_lc;
              cur_hi <= cur_mid;
            end else begin
              stack[sp[IW-1:0]].right <= 1'b1;
              cur_p  <= cur_rc;
              cur_lo <= cur_mid + PW'(1);
            end
            state <= S_VISIT;
          end
          S_RET: begin
            if (sp == '0) begin
              state <= S_DONE;
            end else if (!top.right && (qr > top_mid)) begin
              stack[sp_m1[IW-1:0]].right <= 1'b1;
              cur_p  <= {top.p[AW-2:0], 1'b1};
              cur_lo <= top_mid + PW'(1);
              cur_hi <= top.hi;
              state  <= S_VISIT;
            end else begin
              // Pop; an add must refresh the node's maximum from its children.
              sp <= sp_m1;
              if (op == FN_ADD) begin
                cur_p <= top.p;
                state <= S_FIXL;
              end
            end
          end
          S_FIXL: begin
            tmp   <= rdata.mx;
            state <= S_FIXR;
          end
          S_FIXR: begin
            state <= S_RET;
          end
          S_DONE: begin
            if (!out_valid || out_ready) begin
              out_valid          <= 1'b1;
              out_item.status    <= bad ? ST_BAD : ST_DONE;
              out_item.range_max <= (!bad && (op == FN_MAX)) ? acc_ext[DATA_W-1:0] : '0;
              state              <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst) sp <= SPW'(SD))
    else $error("tree walk stack overflow");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while walking");
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result shown without a finished walk");
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (state == S_CLEAR) && (clr_addr == '0))
    else $error("size write did not start a clearing pass");

endmodule
